@@ design/sqoe_pkg.sv @@
// Shared types and constants for the stack/queue opcode engine.
// No dependencies; imported by sqoe_cell and stack_queue_opcode_engine_unit.
`default_nettype none

package sqoe_pkg;

  localparam int WORD_W = 32;

  // opcodes carried on kind
  localparam logic [2:0] KIND_PUSH = 3'd0;
  localparam logic [2:0] KIND_PALL = 3'd1;
  localparam logic [2:0] KIND_PINT = 3'd2;
  localparam logic [2:0] KIND_POP  = 3'd3;
  localparam logic [2:0] KIND_SWAP = 3'd4;

  // status codes
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_BADARG     = 3'd1;
  localparam logic [2:0] STAT_PINT_EMPTY = 3'd2;
  localparam logic [2:0] STAT_POP_EMPTY  = 3'd3;
  localparam logic [2:0] STAT_SWAP_SHORT = 3'd4;
  localparam logic [2:0] STAT_FULL       = 3'd5;

  // swap needs this many live elements
  localparam int SWAP_MIN = 2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_TOP,
    CELL_PUSH_AT_MARK,
    CELL_POP,
    CELL_SWAP,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [WORD_W-1:0]   value;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } fsm_t;

endpackage

`default_nettype wire

@@ design/sqoe_cell.sv @@
// One storage cell of the element chain: holds one word, takes its neighbour's.
// Depends on sqoe_pkg.
`default_nettype none

module sqoe_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  sqoe_pkg::cell_ctl_t          ctl,
  input  logic [IW-1:0]                mark,
  input  logic [sqoe_pkg::WORD_W-1:0]  up_word,
  input  logic [sqoe_pkg::WORD_W-1:0]  down_word,
  input  logic [sqoe_pkg::WORD_W-1:0]  head_word,
  output logic [sqoe_pkg::WORD_W-1:0]  word
);
  import sqoe_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [WORD_W-1:0] word_next;

  always_comb begin
    word_next = word;
    unique case (ctl.op)
      CELL_HOLD: begin
        word_next = word;
      end
      CELL_PUSH_TOP: begin
        word_next = (MY_IDX == '0) ? ctl.value : up_word;
      end
      CELL_PUSH_AT_MARK: begin
        if (MY_IDX == mark) word_next = ctl.value;
      end
      CELL_POP: begin
        word_next = down_word;
      end
      CELL_SWAP: begin
        if (MY_IDX == IW'(0)) word_next = down_word;
        else if (MY_IDX == IW'(1)) word_next = up_word;
      end
      CELL_ROTATE: begin
        // live span turns up by one; the last live cell takes the head
        if (MY_IDX == mark) word_next = head_word;
        else if (MY_IDX < mark) word_next = down_word;
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

@@ design/stack_queue_opcode_engine_unit.sv @@
// Top level of the stack/queue opcode engine: control and a chain of sqoe_cell.
// Depends on sqoe_pkg and sqoe_cell.
//
//  channel  | handshake                    | words
//  ---------+------------------------------+--------------------------------------
//  command  | start / busy                 | kind, push_value, value_ok
//  result   | strobe (one cycle, no stall) | data_out, has_data, status, last
//  config   | cfg_valid / cfg_ready        | cfg_data -> queue_mode
//
// Element 0 (top) lives in cell 0; the chain shifts for stack push and pop,
// while a queue push writes the slot at mark. Push, pint, pop, swap: result
// in the cycle after acceptance. Pall of n elements: busy while the chain
// rotates one word per cycle past cell 0; n results, then back to idle.
// Synchronous reset empties the store; cell contents are not cleared.
`default_nettype none

module stack_queue_opcode_engine_unit #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic signed [31:0] push_value,
  input  logic               value_ok,
  output logic               strobe,
  output logic signed [31:0] data_out,
  output logic               has_data,
  output logic [2:0]         status,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import sqoe_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fsm_t            state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   walk, walk_next;
  logic            queue_mode;

  logic              strobe_next;
  logic [WORD_W-1:0] data_next;
  logic              has_next;
  logic [2:0]        status_next;
  logic              last_next;

  cell_ctl_t         ctl;
  logic [IW-1:0]     mark;
  logic [WORD_W-1:0] cell_word [DEPTH];
  logic              accept;

  assign busy      = (state == S_WALK);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // mark: insert slot for queue push, last live slot while rotating
  assign mark = busy ? IW'(count - CW'(1)) : count[IW-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] up_w;
    logic [WORD_W-1:0] dn_w;
    if (i == 0) begin : g_first
      assign up_w = ctl.value;
    end else begin : g_up
      assign up_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign dn_w = cell_word[i];
    end else begin : g_dn
      assign dn_w = cell_word[i+1];
    end
    sqoe_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .mark      (mark),
      .up_word   (up_w),
      .down_word (dn_w),
      .head_word (cell_word[0]),
      .word      (cell_word[i])
    );
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    walk_next   = walk;
    ctl.op      = CELL_HOLD;
    ctl.value   = $unsigned(push_value);
    strobe_next = 1'b0;
    data_next   = '0;
    has_next    = 1'b0;
    status_next = STAT_OK;
    last_next   = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          unique case (kind)
            KIND_PUSH: begin
              if (!value_ok) begin
                status_next = STAT_BADARG;
              end else if (count == CW'(DEPTH)) begin
                status_next = STAT_FULL;
              end else begin
                ctl.op     = queue_mode ? CELL_PUSH_AT_MARK : CELL_PUSH_TOP;
                count_next = count + CW'(1);
              end
            end
            KIND_PALL: begin
              if (count != '0) begin
                strobe_next = 1'b0;
                state_next  = S_WALK;
                walk_next   = count;
              end
            end
            KIND_PINT: begin
              if (count == '0) begin
                status_next = STAT_PINT_EMPTY;
              end else begin
                data_next = cell_word[0];
                has_next  = 1'b1;
              end
            end
            KIND_POP: begin
              if (count == '0) begin
                status_next = STAT_POP_EMPTY;
              end else begin
                ctl.op     = CELL_POP;
                count_next = count - CW'(1);
              end
            end
            KIND_SWAP: begin
              if (count < CW'(SWAP_MIN)) begin
                status_next = STAT_SWAP_SHORT;
              end else begin
                ctl.op = CELL_SWAP;
              end
            end
            default: begin
              status_next = STAT_OK;
            end
          endcase
        end
      end
      S_WALK: begin
        ctl.op      = CELL_ROTATE;
        strobe_next = 1'b1;
        data_next   = cell_word[0];
        has_next    = 1'b1;
        last_next   = (walk == CW'(1));
        walk_next   = walk - CW'(1);
        if (walk == CW'(1)) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      walk       <= '0;
      queue_mode <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      walk   <= walk_next;
      strobe <= strobe_next;
      if (cfg_valid && cfg_ready) queue_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= $signed(data_next);
    has_data <= has_next;
    status   <= status_next;
    last     <= last_next;
  end

  // end of a listing always closes with the final word
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> strobe && last)
    else $error("pall ended without a final word");

  // every walking cycle yields a data word
  assert property (@(posedge clk) disable iff (rst) busy |=> strobe && has_data)
    else $error("walk cycle without data word");

  assert property (@(posedge clk) disable iff (rst)
                   (count <= CW'(DEPTH)) && (!busy || count != '0))
    else $error("element count out of range");

endmodule

`default_nettype wire
